// ===== rtl/core/xor_checked_frame_parser_top_assert.svh =====
// Assertion macros used by the frame parser checker.
`ifndef XOR_CHECKED_FRAME_PARSER_TOP_ASSERT_SVH
`define XOR_CHECKED_FRAME_PARSER_TOP_ASSERT_SVH

// Clocked assertion, switched off while reset is asserted
`define XCFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define XCFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/xcfp_pkg.sv =====
// Package: types, codes and constants of the XOR-checked frame parser.
package xcfp_pkg;

    // Sync bytes
    localparam logic [7:0] SYNC_FIRST   = 8'h5A;
    localparam logic [7:0] SYNC_REQUEST = 8'h12;
    localparam logic [7:0] SYNC_ACK     = 8'h34;

    // Reset value of the length limit
    localparam logic [15:0] MAX_LEN_RESET = 16'h0100;

    // Configuration register indexes
    localparam logic CFG_FRAME_KIND = 1'b0;
    localparam logic CFG_MAX_LEN    = 1'b1;

    // Frame kind register values
    localparam logic FRAME_REQUEST = 1'b0;
    localparam logic FRAME_ACK     = 1'b1;

    // Parser phases
    localparam logic [3:0] PH_HUNT   = 4'd0;
    localparam logic [3:0] PH_SYNC2  = 4'd1;
    localparam logic [3:0] PH_ID0    = 4'd2;
    localparam logic [3:0] PH_ID1    = 4'd3;
    localparam logic [3:0] PH_CNT0   = 4'd4;
    localparam logic [3:0] PH_CNT1   = 4'd5;
    localparam logic [3:0] PH_LEN0   = 4'd6;
    localparam logic [3:0] PH_LEN1   = 4'd7;
    localparam logic [3:0] PH_LEN2   = 4'd8;
    localparam logic [3:0] PH_LEN3   = 4'd9;
    localparam logic [3:0] PH_DATA   = 4'd10;
    localparam logic [3:0] PH_CSUM   = 4'd11;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_CSUM_OK  = 2'd1;
    localparam logic [1:0] KIND_CSUM_BAD = 2'd2;

    // One result from the parse engine
    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] offset;
        logic [15:0] frame_id;
        logic [15:0] tx_count;
        logic [15:0] length;
    } result_t;

endpackage

// ===== rtl/core/xcfp_engine.sv =====
// Parse engine: frame state registers and the per-byte next-state logic.
module xcfp_engine
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           byte_in,
    input  logic                 frame_kind,
    input  logic [15:0]          max_len,
    output xcfp_pkg::result_t    res
);

    logic [3:0]  phase_reg,      phase_next;
    logic [15:0] id_acc_reg,     id_acc_next;
    logic [15:0] count_acc_reg,  count_acc_next;
    logic [23:0] len_acc_reg,    len_acc_next;   // low three length bytes
    logic [7:0]  xor_acc_reg,    xor_acc_next;
    logic [15:0] bytes_seen_reg, bytes_seen_next;

    logic [31:0] len_full;
    logic [15:0] seen_inc;
    logic [7:0]  sync2;

    assign len_full = {byte_in, len_acc_reg};
    assign seen_inc = bytes_seen_reg + 16'd1;
    assign sync2    = (frame_kind == xcfp_pkg::FRAME_ACK) ? xcfp_pkg::SYNC_ACK
                                                          : xcfp_pkg::SYNC_REQUEST;

    // Next state and result for the byte at the head of the pipe
    always_comb
    begin
        phase_next      = phase_reg;
        id_acc_next     = id_acc_reg;
        count_acc_next  = count_acc_reg;
        len_acc_next    = len_acc_reg;
        xor_acc_next    = xor_acc_reg ^ byte_in;
        bytes_seen_next = bytes_seen_reg;
        res             = '0;

        case (phase_reg)
            xcfp_pkg::PH_HUNT:
            begin
                xor_acc_next = xor_acc_reg;
                if (byte_in == xcfp_pkg::SYNC_FIRST)
                begin
                    xor_acc_next = byte_in;
                    phase_next   = xcfp_pkg::PH_SYNC2;
                end
            end
            xcfp_pkg::PH_SYNC2:
            begin
                if (byte_in == sync2)
                begin
                    phase_next = xcfp_pkg::PH_ID0;
                end
                else
                begin
                    // wrong sync: back to hunting, byte not re-tested
                    phase_next      = xcfp_pkg::PH_HUNT;
                    id_acc_next     = '0;
                    count_acc_next  = '0;
                    len_acc_next    = '0;
                    xor_acc_next    = '0;
                    bytes_seen_next = '0;
                end
            end
            xcfp_pkg::PH_ID0:
            begin
                id_acc_next = {8'd0, byte_in};
                phase_next  = xcfp_pkg::PH_ID1;
            end
            xcfp_pkg::PH_ID1:
            begin
                id_acc_next = {byte_in, id_acc_reg[7:0]};
                phase_next  = (frame_kind == xcfp_pkg::FRAME_ACK) ? xcfp_pkg::PH_LEN0
                                                                  : xcfp_pkg::PH_CNT0;
            end
            xcfp_pkg::PH_CNT0:
            begin
                count_acc_next = {8'd0, byte_in};
                phase_next     = xcfp_pkg::PH_CNT1;
            end
            xcfp_pkg::PH_CNT1:
            begin
                count_acc_next = {byte_in, count_acc_reg[7:0]};
                phase_next     = xcfp_pkg::PH_LEN0;
            end
            xcfp_pkg::PH_LEN0:
            begin
                len_acc_next = {16'd0, byte_in};
                phase_next   = xcfp_pkg::PH_LEN1;
            end
            xcfp_pkg::PH_LEN1:
            begin
                len_acc_next = {8'd0, byte_in, len_acc_reg[7:0]};
                phase_next   = xcfp_pkg::PH_LEN2;
            end
            xcfp_pkg::PH_LEN2:
            begin
                len_acc_next = {byte_in, len_acc_reg[15:0]};
                phase_next   = xcfp_pkg::PH_LEN3;
            end
            xcfp_pkg::PH_LEN3:
            begin
                bytes_seen_next = '0;
                if (len_full > {16'd0, max_len})
                begin
                    // oversize frame: drop it and hunt again
                    phase_next     = xcfp_pkg::PH_HUNT;
                    id_acc_next    = '0;
                    count_acc_next = '0;
                    len_acc_next   = '0;
                    xor_acc_next   = '0;
                end
                else
                begin
                    // length now fits in 16 bits, top byte is zero
                    phase_next = (len_full[15:0] != 16'd0) ? xcfp_pkg::PH_DATA
                                                           : xcfp_pkg::PH_CSUM;
                end
            end
            xcfp_pkg::PH_DATA:
            begin
                res.valid       = 1'b1;
                res.kind        = xcfp_pkg::KIND_PAYLOAD;
                res.data_byte   = byte_in;
                res.offset      = bytes_seen_reg;
                bytes_seen_next = seen_inc;
                if ({8'd0, seen_inc} >= len_acc_reg)
                begin
                    phase_next = xcfp_pkg::PH_CSUM;
                end
            end
            xcfp_pkg::PH_CSUM:
            begin
                res.valid      = 1'b1;
                res.kind       = (byte_in == xor_acc_reg) ? xcfp_pkg::KIND_CSUM_OK
                                                          : xcfp_pkg::KIND_CSUM_BAD;
                res.data_byte  = byte_in;
                res.frame_id   = id_acc_reg;
                res.tx_count   = (frame_kind == xcfp_pkg::FRAME_ACK) ? 16'd0
                                                                     : count_acc_reg;
                res.length     = len_acc_reg[15:0];
                phase_next      = xcfp_pkg::PH_HUNT;
                id_acc_next     = '0;
                count_acc_next  = '0;
                len_acc_next    = '0;
                xor_acc_next    = '0;
                bytes_seen_next = '0;
            end
            default:
            begin
                // unused phase code: clear and drop the byte
                phase_next      = xcfp_pkg::PH_HUNT;
                id_acc_next     = '0;
                count_acc_next  = '0;
                len_acc_next    = '0;
                xor_acc_next    = '0;
                bytes_seen_next = '0;
            end
        endcase
    end

    // Frame state registers, updated once per processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= xcfp_pkg::PH_HUNT;
            id_acc_reg     <= '0;
            count_acc_reg  <= '0;
            len_acc_reg    <= '0;
            xor_acc_reg    <= '0;
            bytes_seen_reg <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            id_acc_reg     <= id_acc_next;
            count_acc_reg  <= count_acc_next;
            len_acc_reg    <= len_acc_next;
            xor_acc_reg    <= xor_acc_next;
            bytes_seen_reg <= bytes_seen_next;
        end
    end

endmodule

// ===== rtl/core/xor_checked_frame_parser_top.sv =====
// Top level of the XOR-checked frame parser: byte input, config and result registers.
// The parser takes one received byte per cycle while in_ready is high, and a new byte
// may be accepted in every such cycle. A byte first lands in an input register; when
// the result side is free, the parse engine updates the frame state from it and, for
// payload and checksum bytes, loads the result register that drives the outputs.
// The result register holds a waiting result while the input register keeps
// filling; in_ready drops only when both are full and out_ready is low. Sync,
// header and oversize-length bytes produce no result. Write frame_kind and
// max_len only while no transaction is in flight; a change takes effect from the
// next byte, even in the middle of a frame.
module xor_checked_frame_parser_top
(
    input  logic        clk,
    input  logic        rst_n,
    // byte input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    // result output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [15:0] offset,
    output logic [15:0] frame_id,
    output logic [15:0] tx_count,
    output logic [15:0] length,
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic        frame_kind_reg;
    logic [15:0] max_len_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  data_byte_reg;
    logic [15:0] offset_reg;
    logic [15:0] frame_id_reg;
    logic [15:0] tx_count_reg;
    logic [15:0] length_reg;

    logic              out_free;
    logic              step;
    logic              in_take;
    xcfp_pkg::result_t res;

    assign out_free = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;
    assign in_take  = in_valid && in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_kind_reg <= xcfp_pkg::FRAME_REQUEST;
            max_len_reg    <= xcfp_pkg::MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                xcfp_pkg::CFG_FRAME_KIND: frame_kind_reg <= cfg_wdata[0];
                xcfp_pkg::CFG_MAX_LEN:    max_len_reg    <= cfg_wdata;
                default:                  max_len_reg    <= max_len_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    xcfp_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .byte_in    (in_byte_reg),
        .frame_kind (frame_kind_reg),
        .max_len    (max_len_reg),
        .res        (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step && res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res.valid)
        begin
            kind_reg       <= res.kind;
            data_byte_reg  <= res.data_byte;
            offset_reg     <= res.offset;
            frame_id_reg   <= res.frame_id;
            tx_count_reg   <= res.tx_count;
            length_reg     <= res.length;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign data_byte  = data_byte_reg;
    assign offset     = offset_reg;
    assign frame_id   = frame_id_reg;
    assign tx_count   = tx_count_reg;
    assign length     = length_reg;

endmodule

// ===== rtl/core/xcfp_checker.sv =====
// Port-level checker for the frame parser, bound to the top level.
`include "xor_checked_frame_parser_top_assert.svh"

module xcfp_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    input  logic [15:0] offset,
    input  logic [15:0] frame_id,
    input  logic [15:0] tx_count,
    input  logic [15:0] length,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    // A stalled result transaction holds its payload
    `XCFP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte) && $stable(offset) && $stable(frame_id) && $stable(tx_count) && $stable(length), "stalled result changed")

    // Payload results carry no frame summary
    `XCFP_ASSERT(a_payload_clean, clk, rst_n, out_valid && kind == xcfp_pkg::KIND_PAYLOAD |-> frame_id == 16'd0 && tx_count == 16'd0 && length == 16'd0, "payload result with frame fields")

    // Frame results carry a zero offset and a defined kind
    `XCFP_ASSERT(a_frame_clean, clk, rst_n, out_valid && kind != xcfp_pkg::KIND_PAYLOAD |-> offset == 16'd0 && (kind == xcfp_pkg::KIND_CSUM_OK || kind == xcfp_pkg::KIND_CSUM_BAD), "bad frame result")

    // With the result side free, input is never throttled
    `XCFP_ASSERT(a_ready_free, clk, rst_n, !out_valid |-> in_ready, "input stalled with empty output")

    // No result during reset
    `XCFP_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !out_valid, "result valid in reset")

endmodule

bind xor_checked_frame_parser_top xcfp_checker u_xcfp_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .data_byte  (data_byte),
    .offset     (offset),
    .frame_id   (frame_id),
    .tx_count   (tx_count),
    .length     (length),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
);

// ===== test/tb_xor_checked_frame_parser_top.sv =====
// Testbench for the XOR-checked frame parser: directed rows, random frames, result scoreboard.
`timescale 1ns / 1ps

module tb_xor_checked_frame_parser_top;

    localparam int unsigned CYCLE_LIMIT = 1000000;

    // One result transaction, field by field
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] offset;
        logic [15:0] frame_id;
        logic [15:0] tx_count;
        logic [15:0] length;
    } parse_res_t;

    // Directed row: a received byte (with an optional hand-written result) or a register write
    typedef struct packed {
        bit          is_cfg;
        logic        cfg_idx;
        logic [15:0] value;
        bit          fixed;
        parse_res_t  want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] offset;
    logic [15:0] frame_id;
    logic [15:0] tx_count;
    logic [15:0] length;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    // Register copies and parser state of the predictor
    logic        cfg_kind;
    logic [15:0] cfg_max_len;
    logic [3:0]  st_phase;
    logic [15:0] st_id;
    logic [15:0] st_count;
    logic [31:0] st_len;
    logic [7:0]  st_xor;
    logic [15:0] st_seen;

    parse_res_t  pending_results[$];
    dir_row_t    dir_rows[$];
    bit          steady_flow;
    int          error_count;
    int          bytes_accepted;
    int          bytes_counted;
    int          payload_seen;
    int          frames_good;
    int          frames_bad;
    int unsigned cycle_count;

    xor_checked_frame_parser_top i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .data_byte  (data_byte),
        .offset     (offset),
        .frame_id   (frame_id),
        .tx_count   (tx_count),
        .length     (length),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    always #10 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("tb_xor_checked_frame_parser_top NOT OK");
            $finish;
        end
    end

    // Receiver back-pressure, changed at the falling edge
    always @(negedge clk)
    begin
        out_ready <= steady_flow ? 1'b1 : ($urandom_range(0, 99) >= 27);
    end

    function automatic parse_res_t make_result(input logic [1:0] k, input logic [7:0] d,
                                               input logic [15:0] off, input logic [15:0] fid,
                                               input logic [15:0] cnt, input logic [15:0] len);
        parse_res_t r;
        r.kind       = k;
        r.data_byte  = d;
        r.offset     = off;
        r.frame_id   = fid;
        r.tx_count   = cnt;
        r.length     = len;
        return r;
    endfunction

    task automatic clear_frame_state();
        st_phase = xcfp_pkg::PH_HUNT;
        st_id    = '0;
        st_count = '0;
        st_len   = '0;
        st_xor   = '0;
        st_seen  = '0;
    endtask

    // Frame parser prediction: one received byte in, at most one result out
    task automatic parse_rx_byte(input logic [7:0] b, output bit has_res, output parse_res_t res);
        has_res = 1'b0;
        res     = '0;
        case (st_phase)
            xcfp_pkg::PH_HUNT:
                if (b == xcfp_pkg::SYNC_FIRST)
                begin
                    st_xor   = b;
                    st_phase = xcfp_pkg::PH_SYNC2;
                end
            xcfp_pkg::PH_SYNC2:
                // a bad second sync byte is dropped, not retried as a first sync
                if (b == ((cfg_kind == xcfp_pkg::FRAME_ACK) ? xcfp_pkg::SYNC_ACK
                                                            : xcfp_pkg::SYNC_REQUEST))
                begin
                    st_xor   ^= b;
                    st_phase = xcfp_pkg::PH_ID0;
                end
                else
                    clear_frame_state();
            xcfp_pkg::PH_ID0:
            begin
                st_id    = {8'h00, b};
                st_xor   ^= b;
                st_phase = xcfp_pkg::PH_ID1;
            end
            xcfp_pkg::PH_ID1:
            begin
                st_id[15:8] = b;
                st_xor      ^= b;
                st_phase    = (cfg_kind == xcfp_pkg::FRAME_ACK) ? xcfp_pkg::PH_LEN0
                                                                : xcfp_pkg::PH_CNT0;
            end
            xcfp_pkg::PH_CNT0:
            begin
                st_count = {8'h00, b};
                st_xor   ^= b;
                st_phase = xcfp_pkg::PH_CNT1;
            end
            xcfp_pkg::PH_CNT1:
            begin
                st_count[15:8] = b;
                st_xor         ^= b;
                st_phase       = xcfp_pkg::PH_LEN0;
            end
            xcfp_pkg::PH_LEN0:
            begin
                st_len   = {24'h0, b};
                st_xor   ^= b;
                st_phase = xcfp_pkg::PH_LEN1;
            end
            xcfp_pkg::PH_LEN1:
            begin
                st_len[15:8] = b;
                st_xor       ^= b;
                st_phase     = xcfp_pkg::PH_LEN2;
            end
            xcfp_pkg::PH_LEN2:
            begin
                st_len[23:16] = b;
                st_xor        ^= b;
                st_phase      = xcfp_pkg::PH_LEN3;
            end
            xcfp_pkg::PH_LEN3:
            begin
                st_len[31:24] = b;
                st_xor        ^= b;
                st_seen       = '0;
                // length compared as unsigned 32 bits
                if (st_len > {16'h0000, cfg_max_len})
                    clear_frame_state();
                else if (st_len != 0)
                    st_phase = xcfp_pkg::PH_DATA;
                else
                    st_phase = xcfp_pkg::PH_CSUM;
            end
            xcfp_pkg::PH_DATA:
            begin
                has_res = 1'b1;
                res     = make_result(xcfp_pkg::KIND_PAYLOAD, b, st_seen, '0, '0, '0);
                st_xor  ^= b;
                st_seen = st_seen + 16'd1;
                if ({16'h0000, st_seen} >= st_len)
                    st_phase = xcfp_pkg::PH_CSUM;
            end
            xcfp_pkg::PH_CSUM:
            begin
                has_res = 1'b1;
                res     = make_result((b == st_xor) ? xcfp_pkg::KIND_CSUM_OK
                                                    : xcfp_pkg::KIND_CSUM_BAD,
                                      b, '0, st_id,
                                      (cfg_kind == xcfp_pkg::FRAME_ACK) ? 16'h0000 : st_count,
                                      st_len[15:0]);
                clear_frame_state();
            end
            default:
                clear_frame_state();
        endcase
    endtask

    // Drive one byte transaction; queue the expected result once it is accepted
    task automatic send_rx(input logic [7:0] b, input bit fixed, input parse_res_t fixed_res);
        bit         has_res;
        parse_res_t res;
        @(negedge clk);
        while (!steady_flow && $urandom_range(0, 99) < 27)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        parse_rx_byte(b, has_res, res);
        if (fixed)
            pending_results.push_back(fixed_res);
        else if (has_res)
            pending_results.push_back(res);
        bytes_accepted++;
    endtask

    // Stop sending, wait for every expected result, then let the engine settle
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [15:0] val);
        wait_for_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == xcfp_pkg::CFG_FRAME_KIND)
            cfg_kind = val[0];
        else
            cfg_max_len = val;
    endtask

    // All-ones bytes push any open frame to its end: a length of that kind always aborts
    task automatic flush_to_hunt();
        while (st_phase != xcfp_pkg::PH_HUNT)
            send_rx(8'hFF, 1'b0, '0);
    endtask

    task automatic set_mode(input logic fkind, input logic [15:0] maxl);
        flush_to_hunt();
        write_cfg(xcfp_pkg::CFG_FRAME_KIND, {15'h0000, fkind});
        write_cfg(xcfp_pkg::CFG_MAX_LEN, maxl);
    endtask

    // Build and send one frame for the current mode; keep > 0 cuts it short
    task automatic emit_frame(input logic [15:0] fid, input logic [15:0] cnt,
                              input logic [31:0] flen, input bit good, input int keep);
        logic [7:0] seq[$];
        logic [7:0] x;
        int         i;
        seq.push_back(xcfp_pkg::SYNC_FIRST);
        seq.push_back((cfg_kind == xcfp_pkg::FRAME_ACK) ? xcfp_pkg::SYNC_ACK
                                                        : xcfp_pkg::SYNC_REQUEST);
        seq.push_back(fid[7:0]);
        seq.push_back(fid[15:8]);
        if (cfg_kind == xcfp_pkg::FRAME_REQUEST)
        begin
            seq.push_back(cnt[7:0]);
            seq.push_back(cnt[15:8]);
        end
        for (i = 0; i < 4; i++)
            seq.push_back(flen[8*i +: 8]);
        // oversize frames stop after the header
        if (flen <= {16'h0000, cfg_max_len})
        begin
            for (i = 0; i < int'(flen); i++)
                seq.push_back(8'($urandom));
            x = '0;
            foreach (seq[j])
                x ^= seq[j];
            seq.push_back(good ? x : (x ^ 8'($urandom_range(1, 255))));
        end
        if (keep > 0 && keep < seq.size())
            seq = seq[0:keep-1];
        foreach (seq[j])
            send_rx(seq[j], 1'b0, '0);
        bytes_counted += seq.size();
    endtask

    // One random sequence: mostly well-formed frames, the rest broken ones and line noise
    task automatic random_sequence();
        int          pick;
        int          cap;
        logic [31:0] flen;
        logic [7:0]  b2;
        pick = $urandom_range(0, 99);
        cap  = (cfg_max_len < 40) ? int'(cfg_max_len) : 40;
        flen = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(0, cap));
        if (pick < 70)
        begin
            if (cfg_max_len <= 300 && $urandom_range(0, 19) == 0)
                flen = {16'h0000, cfg_max_len};
            emit_frame(16'($urandom), 16'($urandom), flen, $urandom_range(0, 6) != 0, 0);
        end
        else if (pick < 78)
        begin
            // over the limit, sometimes only through the upper length bytes
            if (cfg_max_len == 16'hFFFF || $urandom_range(0, 1) == 0)
                flen = {16'($urandom_range(1, 65535)), 16'($urandom)};
            else
                flen = {16'h0000, cfg_max_len} + 32'($urandom_range(1, 50));
            emit_frame(16'($urandom), 16'($urandom), flen, 1'b1, 0);
        end
        else if (pick < 85)
        begin
            b2 = 8'($urandom);
            if (b2 == ((cfg_kind == xcfp_pkg::FRAME_ACK) ? xcfp_pkg::SYNC_ACK
                                                         : xcfp_pkg::SYNC_REQUEST))
                b2 = xcfp_pkg::SYNC_FIRST;
            send_rx(xcfp_pkg::SYNC_FIRST, 1'b0, '0);
            send_rx(b2, 1'b0, '0);
            bytes_counted += 2;
        end
        else if (pick < 92)
        begin
            repeat ($urandom_range(1, 6)) send_rx(8'($urandom), 1'b0, '0);
        end
        else
        begin
            emit_frame(16'($urandom), 16'($urandom), flen, 1'b1, $urandom_range(2, 9));
            flush_to_hunt();
        end
    endtask

    task automatic run_random(input int n);
        int target;
        target = bytes_counted + n;
        while (bytes_counted < target)
            random_sequence();
    endtask

    function automatic dir_row_t row_rx(input logic [7:0] b);
        dir_row_t r;
        r        = '0;
        r.value  = {8'h00, b};
        return r;
    endfunction

    function automatic dir_row_t row_rx_res(input logic [7:0] b, input parse_res_t want);
        dir_row_t r;
        r       = row_rx(b);
        r.fixed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic dir_row_t row_cfg(input logic idx, input logic [15:0] val);
        dir_row_t r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.cfg_idx = idx;
        r.value   = val;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, fname, want, got);
        end
    endtask

    // Result scoreboard: every accepted transaction against the oldest expectation
    always @(posedge clk)
    begin : result_check
        parse_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result: expected none, got kind %0d data %0h",
                         $time, kind, data_byte);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", {14'h0000, want.kind}, {14'h0000, kind});
                check_field("data_byte", {8'h00, want.data_byte}, {8'h00, data_byte});
                check_field("offset", want.offset, offset);
                check_field("frame_id", want.frame_id, frame_id);
                check_field("tx_count", want.tx_count, tx_count);
                check_field("length", want.length, length);
                if (want.kind == xcfp_pkg::KIND_PAYLOAD)
                    payload_seen++;
                else if (want.kind == xcfp_pkg::KIND_CSUM_OK)
                    frames_good++;
                else
                    frames_bad++;
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        rx_byte     = '0;
        out_ready   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = xcfp_pkg::CFG_FRAME_KIND;
        cfg_wdata   = '0;
        steady_flow = 1'b0;
        cfg_kind    = xcfp_pkg::FRAME_REQUEST;
        cfg_max_len = xcfp_pkg::MAX_LEN_RESET;
        clear_frame_state();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows, reset settings: request frames, limit 256.
        // Wrong second sync: the repeated 5A must not restart, so the 12 is ignored
        dir_rows.push_back(row_rx(xcfp_pkg::SYNC_FIRST));
        dir_rows.push_back(row_rx(xcfp_pkg::SYNC_FIRST));
        dir_rows.push_back(row_rx(xcfp_pkg::SYNC_REQUEST));
        // request with id and count all ones, one payload byte, good checksum
        dir_rows.push_back(row_rx(xcfp_pkg::SYNC_FIRST));
        dir_rows.push_back(row_rx(xcfp_pkg::SYNC_REQUEST));
        repeat (4) dir_rows.push_back(row_rx(8'hFF));
        dir_rows.push_back(row_rx(8'h01));
        repeat (3) dir_rows.push_back(row_rx(8'h00));
        dir_rows.push_back(row_rx_res(8'hFF, make_result(xcfp_pkg::KIND_PAYLOAD, 8'hFF,
                                                         '0, '0, '0, '0)));
        dir_rows.push_back(row_rx(8'hB6));
        // ack frames, nothing but empty payloads allowed
        dir_rows.push_back(row_cfg(xcfp_pkg::CFG_FRAME_KIND, {15'h0000, xcfp_pkg::FRAME_ACK}));
        dir_rows.push_back(row_cfg(xcfp_pkg::CFG_MAX_LEN, 16'h0000));
        // zero-length ack with a bad checksum
        dir_rows.push_back(row_rx(xcfp_pkg::SYNC_FIRST));
        dir_rows.push_back(row_rx(xcfp_pkg::SYNC_ACK));
        repeat (6) dir_rows.push_back(row_rx(8'h00));
        dir_rows.push_back(row_rx_res(8'h00, make_result(xcfp_pkg::KIND_CSUM_BAD, 8'h00,
                                                         '0, '0, '0, '0)));
        // length with only bit 31 set: far over the limit, frame dropped
        dir_rows.push_back(row_rx(xcfp_pkg::SYNC_FIRST));
        dir_rows.push_back(row_rx(xcfp_pkg::SYNC_ACK));
        repeat (5) dir_rows.push_back(row_rx(8'h00));
        dir_rows.push_back(row_rx(8'h80));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_cfg(dir_rows[i].cfg_idx, dir_rows[i].value);
            else
                send_rx(dir_rows[i].value[7:0], dir_rows[i].fixed, dir_rows[i].want);
        end

        // Random part over several register settings
        set_mode(xcfp_pkg::FRAME_ACK, 16'h0000);
        run_random(150);

        set_mode(xcfp_pkg::FRAME_REQUEST, 16'd16);
        run_random(250);
        wait_for_results();
        run_random(200);

        // long payload, then a length just past the widest limit
        set_mode(xcfp_pkg::FRAME_ACK, 16'hFFFF);
        emit_frame(16'($urandom), 16'($urandom), 32'd200, 1'b1, 0);
        emit_frame(16'($urandom), 16'($urandom), 32'h0001_0000, 1'b1, 0);
        run_random(100);

        set_mode(xcfp_pkg::FRAME_REQUEST, 16'hFFFF);
        run_random(250);

        // long stretch without idling on either side
        set_mode(xcfp_pkg::FRAME_REQUEST, 16'($urandom_range(17, 1000)));
        steady_flow = 1'b1;
        run_random(300);
        steady_flow = 1'b0;
        run_random(100);

        wait_for_results();
        repeat (10) @(posedge clk);

        $display("Run covered %0d byte transactions: %0d payload bytes, %0d good and %0d bad frames.",
                 bytes_accepted, payload_seen, frames_good, frames_bad);
        $display("Request and ack frames, length limits 0 to 65535, aborts and resyncs included.");
        if (error_count == 0)
            $display("tb_xor_checked_frame_parser_top OK");
        else
            $display("tb_xor_checked_frame_parser_top NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/xcfp_pkg.sv
rtl/core/xcfp_engine.sv
rtl/core/xor_checked_frame_parser_top.sv
rtl/core/xcfp_checker.sv
test/tb_xor_checked_frame_parser_top.sv
